>>> rtl/blfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfs_pkg
// Shared types and band limits for the band-locked frequency stepper.
// ----------------------------------------------------------------------------
package blfs_pkg;

  localparam int FREQ_W = 28;
  localparam int STEP_W = 20;
  localparam int IDX_W  = 2;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam freq_t BAND1_LO   = 28'd10800000;
  localparam freq_t BAND1_HI   = 28'd13600000;
  localparam freq_t BAND2_LO   = 28'd14400000;
  localparam freq_t BAND2_HI   = 28'd14600000;
  localparam freq_t BAND3_LO   = 28'd43000000;
  localparam freq_t BAND3_HI   = 28'd44000000;
  localparam freq_t OPEN_LO    = 28'd1000000;
  localparam freq_t OPEN_HI    = 28'd130000000;
  localparam freq_t RESET_FREQ = 28'd43002500;
  localparam step_t RESET_STEP = 20'd2500;

  typedef enum logic [1:0] {
    KIND_UP    = 2'd0,
    KIND_DOWN  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BAND_LOCK    = 2'd0,
    REG_STEP_SIZE    = 2'd1,
    REG_REVERSE_MODE = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic  band_lock;
    step_t step_size;
    logic  reverse_mode;
  } blfs_cfg_t;

  typedef struct packed {
    freq_t rx;
    freq_t tx;
    freq_t shown;
    logic  accepted;
  } blfs_res_t;

endpackage

>>> rtl/blfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfs_datapath
// Next receive/transmit values for one beat: step with gap skip and wrap
// (band lock) or clamp, or range-checked direct entry.
// ----------------------------------------------------------------------------
module blfs_datapath
  import blfs_pkg::*;
(
  input  blfs_cfg_t cfg,
  input  kind_t     kind,
  input  freq_t     entry_freq,
  input  freq_t     rx_cur,
  input  freq_t     tx_cur,
  output blfs_res_t res
);

  freq_t             base;
  logic [FREQ_W:0]   up_v;
  freq_t             dn_v;
  freq_t             up_f;
  freq_t             dn_f;
  logic              entry_ok;
  freq_t             rx_n;
  freq_t             tx_n;
  logic              acc;

  assign base = cfg.reverse_mode ? tx_cur : rx_cur;

  // step up at full width, then skip gaps and wrap (band lock) or clamp
  always_comb begin
    up_v = {1'b0, base} + {{(FREQ_W + 1 - STEP_W){1'b0}}, cfg.step_size};
    if (cfg.band_lock) begin
      if (up_v > {1'b0, BAND1_HI} && up_v < {1'b0, BAND2_LO}) begin
        up_v = {1'b0, BAND2_LO};
      end
      if (up_v > {1'b0, BAND2_HI} && up_v < {1'b0, BAND3_LO}) begin
        up_v = {1'b0, BAND3_LO};
      end
      if (up_v > {1'b0, BAND3_HI}) begin
        up_v = {1'b0, BAND1_LO};
      end
    end else if (up_v > {1'b0, OPEN_HI}) begin
      up_v = {1'b0, OPEN_HI};
    end
    up_f = up_v[FREQ_W-1:0];
  end

  // step down saturating at zero, then skip gaps and wrap (band lock) or clamp
  always_comb begin
    if (base > {{(FREQ_W - STEP_W){1'b0}}, cfg.step_size}) begin
      dn_v = base - {{(FREQ_W - STEP_W){1'b0}}, cfg.step_size};
    end else begin
      dn_v = '0;
    end
    if (cfg.band_lock) begin
      if (dn_v < BAND1_LO) begin
        dn_v = BAND3_HI;
      end
      if (dn_v > BAND1_HI && dn_v < BAND2_LO) begin
        dn_v = BAND1_HI;
      end
      if (dn_v > BAND2_HI && dn_v < BAND3_LO) begin
        dn_v = BAND2_HI;
      end
    end else if (dn_v < OPEN_LO) begin
      dn_v = OPEN_LO;
    end
    dn_f = dn_v;
  end

  always_comb begin
    if (cfg.band_lock) begin
      entry_ok = (entry_freq >= BAND1_LO && entry_freq <= BAND1_HI) ||
                 (entry_freq >= BAND2_LO && entry_freq <= BAND2_HI) ||
                 (entry_freq >= BAND3_LO && entry_freq <= BAND3_HI);
    end else begin
      entry_ok = entry_freq >= OPEN_LO && entry_freq <= OPEN_HI;
    end
  end

  always_comb begin
    rx_n = rx_cur;
    tx_n = tx_cur;
    acc  = 1'b1;
    case (kind)
      KIND_UP, KIND_DOWN: begin
        if (cfg.reverse_mode) begin
          tx_n = (kind == KIND_UP) ? up_f : dn_f;
        end else begin
          rx_n = (kind == KIND_UP) ? up_f : dn_f;
          tx_n = rx_n;
        end
      end
      KIND_ENTRY: begin
        if (entry_ok) begin
          if (!cfg.reverse_mode) begin
            rx_n = entry_freq;
          end
          tx_n = entry_freq;
        end else begin
          acc = 1'b0;
        end
      end
      default: begin
        acc = 1'b1;
      end
    endcase
  end

  assign res.rx       = rx_n;
  assign res.tx       = tx_n;
  assign res.shown    = cfg.reverse_mode ? tx_n : rx_n;
  assign res.accepted = acc;

endmodule

>>> rtl/band_locked_frequency_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_locked_frequency_stepper_core
// Receive/transmit tuning register pair with band-locked stepping and entry.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register loaded together with the
//   frequency state. Throughput: 1 beat per cycle unless out_ready stalls;
//   the state update is one add/subtract and a few constant compares
//   between the input register and the result register.
// Reset (synchronous, rst_n low): frequencies to 430.025 MHz, step 25 kHz,
//   band lock and reverse mode off, pipeline empty.
// ----------------------------------------------------------------------------
module band_locked_frequency_stepper_core
  import blfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_idx,
  input  logic [STEP_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [FREQ_W-1:0] in_entry_freq,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FREQ_W-1:0] out_rx_freq,
  output logic [FREQ_W-1:0] out_tx_freq,
  output logic [FREQ_W-1:0] out_shown_freq,
  output logic              out_accepted
);

  blfs_cfg_t cfg_r;
  freq_t     rx_r;
  freq_t     tx_r;
  logic      stage_vld_r;
  kind_t     kind_r;
  freq_t     entry_r;
  logic      out_vld_r;
  blfs_res_t res_r;
  blfs_res_t res_nxt;
  logic      stage_adv;

  assign stage_adv = stage_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !stage_vld_r || stage_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_lock    <= 1'b0;
      cfg_r.step_size    <= RESET_STEP;
      cfg_r.reverse_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_idx))
        REG_BAND_LOCK:    cfg_r.band_lock    <= cfg_data[0];
        REG_STEP_SIZE:    cfg_r.step_size    <= cfg_data;
        REG_REVERSE_MODE: cfg_r.reverse_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_ready) begin
      stage_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r  <= kind_t'(in_kind);
      entry_r <= in_entry_freq;
    end
  end

  blfs_datapath u_dp (
    .cfg        (cfg_r),
    .kind       (kind_r),
    .entry_freq (entry_r),
    .rx_cur     (rx_r),
    .tx_cur     (tx_r),
    .res        (res_nxt)
  );

  // frequency state and result register advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r      <= RESET_FREQ;
      tx_r      <= RESET_FREQ;
      out_vld_r <= 1'b0;
    end else begin
      if (stage_adv) begin
        rx_r      <= res_nxt.rx;
        tx_r      <= res_nxt.tx;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_rx_freq    = res_r.rx;
  assign out_tx_freq    = res_r.tx;
  assign out_shown_freq = res_r.shown;
  assign out_accepted   = res_r.accepted;

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_adv |=> $stable(rx_r) && $stable(tx_r))
    else $error("frequency state moved without a beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stage_vld_r && !stage_adv |-> !in_ready)
    else $error("held input beat could be overwritten");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    stage_adv |=> out_vld_r)
    else $error("result register not loaded after advance");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.rx == rx_r) && (res_r.tx == tx_r))
    else $error("pending result differs from frequency state");

endmodule
